@@ hdl/ssag_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssag_pkg
// Shared constants, register codes, lane word type and field helper for the
// strided slice address generator.
// ----------------------------------------------------------------------------
package ssag_pkg;

  localparam int MAX_DIMS  = 4;
  localparam int DIM_BITS  = 16;
  localparam int WORD_W    = 32;
  localparam int PACK_W    = 64;
  localparam int DIM_CNT_W = 3;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_MODE         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_COUNT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ELEM_COUNT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_SHAPE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_SHAPE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSETS      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STEPS        = 3'd6;

  localparam logic MODE_GATHER  = 1'b0;
  localparam logic MODE_SCATTER = 1'b1;

  localparam logic [PACK_W-1:0] SHAPE_RESET = 64'h0001_0001_0001_0001;

  typedef struct packed {
    logic [WORD_W-1:0] dest;
    logic [WORD_W-1:0] src;
    logic              ok;
    logic [WORD_W-1:0] idx;
    logic [WORD_W-1:0] gmap;
    logic              inr;
  } lane_t;

  function automatic logic [DIM_BITS-1:0] field_of(input logic [PACK_W-1:0] pk,
                                                   input int d);
    logic [PACK_W-1:0] sh;
    sh = '0;
    if (DIM_BITS * d < PACK_W) begin
      sh = pk >> (DIM_BITS * d);
    end
    return sh[DIM_BITS-1:0];
  endfunction

endpackage

@@ hdl/strided_slice_address_generator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strided_slice_address_generator
// Maps destination flat indices to source element offsets for strided slices.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries a destination flat index; result
// channel out_valid/out_ready carries the echoed index, the source offset and
// the copy flag. Indices at or above element_count are dropped inside.
// Configuration is written through cfg_we/cfg_index/cfg_wdata; the user
// must write only while idle, unenforced; source strides settle after a write.
// Each dimension slot has a 32-stage divider for the coordinate, one mapping
// stage, a 32-stage divider for the scatter step, and two stages for the
// stride multiply and accumulate. Every word passes the input register, all
// slots and the output register for any dimension count. One word is accepted
// per cycle while in_ready is high. When out_ready is low with a result held,
// the whole pipeline holds and in_ready drops; nothing is lost or repeated.
// Reset (rst_n low at a clock edge) empties the pipeline and restores gather
// mode, one dimension, element_count zero, unit shapes and steps.
// ----------------------------------------------------------------------------
module strided_slice_address_generator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ssag_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ssag_pkg::PACK_W-1:0]    cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ssag_pkg::WORD_W-1:0]    in_flat_index,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ssag_pkg::WORD_W-1:0]    out_dest_index,
  output logic [ssag_pkg::WORD_W-1:0]    out_source_offset,
  output logic                           out_copy_src
);
  import ssag_pkg::*;

  localparam logic [DIM_CNT_W-1:0] MAX_N = DIM_CNT_W'(MAX_DIMS);

  logic                 mode_r;
  logic [DIM_CNT_W-1:0] dim_count_r;
  logic [WORD_W-1:0]    elem_count_r;
  logic [PACK_W-1:0]    dest_shape_r;
  logic [PACK_W-1:0]    src_shape_r;
  logic [PACK_W-1:0]    offsets_r;
  logic [PACK_W-1:0]    steps_r;
  logic [WORD_W-1:0]    stride_r [MAX_DIMS];
  logic [DIM_CNT_W-1:0] n_used;

  logic                 en;
  logic                 v0_r;
  lane_t                l0_r;
  logic                 sv_w [MAX_DIMS+1];
  lane_t                sl_w [MAX_DIMS+1];

  logic                 out_valid_r;
  logic [WORD_W-1:0]    out_dest_r;
  logic [WORD_W-1:0]    out_src_r;
  logic                 out_inb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_GATHER;
      dim_count_r  <= DIM_CNT_W'(1);
      elem_count_r <= '0;
      dest_shape_r <= SHAPE_RESET;
      src_shape_r  <= SHAPE_RESET;
      offsets_r    <= '0;
      steps_r      <= SHAPE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:         mode_r       <= cfg_wdata[0];
        REG_DIM_COUNT:    dim_count_r  <= cfg_wdata[DIM_CNT_W-1:0];
        REG_ELEM_COUNT:   elem_count_r <= cfg_wdata[WORD_W-1:0];
        REG_DEST_SHAPE:   dest_shape_r <= cfg_wdata;
        REG_SOURCE_SHAPE: src_shape_r  <= cfg_wdata;
        REG_OFFSETS:      offsets_r    <= cfg_wdata;
        REG_STEPS:        steps_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign n_used = (dim_count_r > MAX_N) ? MAX_N : dim_count_r;

  // settle strides from the innermost dimension outward
  for (genvar d = 0; d < MAX_DIMS; d++) begin : g_stride
    logic [WORD_W-1:0] stride_nxt;
    if (d == MAX_DIMS - 1) begin : g_last
      assign stride_nxt = (int'(n_used) == d + 1) ? WORD_W'(1) : '0;
    end else begin : g_inner
      logic [WORD_W-1:0] prod;
      assign prod = stride_r[d+1] * WORD_W'(field_of(src_shape_r, d + 1));
      assign stride_nxt = (int'(n_used) == d + 1) ? WORD_W'(1) :
                          (int'(n_used) >  d + 1) ? prod : '0;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stride_r[d] <= (d == 0) ? WORD_W'(1) : '0;
      end else begin
        stride_r[d] <= stride_nxt;
      end
    end
  end

  assign en       = ~out_valid_r | out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid & (in_flat_index < elem_count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l0_r.dest <= in_flat_index;
      l0_r.src  <= '0;
      l0_r.ok   <= 1'b1;
      l0_r.idx  <= in_flat_index;
      l0_r.gmap <= '0;
      l0_r.inr  <= 1'b1;
    end
  end

  assign sv_w[0] = v0_r;
  assign sl_w[0] = l0_r;

  for (genvar j = 0; j < MAX_DIMS; j++) begin : g_slot
    logic                  act;
    logic [DIM_BITS-1:0]   sz;
    logic [DIM_BITS-1:0]   off;
    logic [DIM_BITS-1:0]   stp;
    logic [DIM_BITS-1:0]   ssz;
    logic [WORD_W-1:0]     strd;

    logic                  a_v;
    logic [WORD_W-1:0]     a_num;
    logic [WORD_W-1:0]     a_q;
    logic [DIM_BITS-1:0]   a_r;
    lane_t                 a_l;

    logic [WORD_W-1:0]     coord;
    logic [2*DIM_BITS-1:0] span;
    logic [WORD_W:0]       span_end;
    logic [WORD_W-1:0]     off_w;
    logic [WORD_W-1:0]     gprod;
    lane_t                 mp_nxt;
    logic                  mp_v_r;
    lane_t                 mp_l_r;
    logic [WORD_W-1:0]     mp_rel_r;

    logic                  b_v;
    logic [WORD_W-1:0]     b_num;
    logic [WORD_W-1:0]     b_q;
    logic [DIM_BITS-1:0]   b_r;
    lane_t                 b_l;

    logic [WORD_W-1:0]     mapped;
    logic                  bad;
    lane_t                 m1_nxt;
    lane_t                 m2_nxt;
    logic                  m1_v_r;
    lane_t                 m1_l_r;
    logic [WORD_W-1:0]     m1_p_r;
    logic                  m2_v_r;
    lane_t                 m2_l_r;

    assign act = int'(n_used) > j;

    always_comb begin
      sz   = '0;
      off  = '0;
      stp  = '0;
      ssz  = '0;
      strd = '0;
      for (int d = 0; d < MAX_DIMS; d++) begin
        if (act && (int'(n_used) - 1 - j == d)) begin
          sz   = field_of(dest_shape_r, d);
          off  = field_of(offsets_r, d);
          stp  = field_of(steps_r, d);
          ssz  = field_of(src_shape_r, d);
          strd = stride_r[d];
        end
      end
    end

    ssag_div u_div_coord (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (sv_w[j]),
      .in_num   (sl_w[j].idx),
      .in_lane  (sl_w[j]),
      .divisor  (sz),
      .out_valid(a_v),
      .out_num  (a_num),
      .out_q    (a_q),
      .out_r    (a_r),
      .out_lane (a_l)
    );

    assign coord    = (sz == '0) ? a_num : WORD_W'(a_r);
    assign off_w    = WORD_W'(off);
    assign span     = stp * ssz;
    assign span_end = (WORD_W+1)'(off) + (WORD_W+1)'(span);
    assign gprod    = WORD_W'(stp) * coord;

    always_comb begin
      mp_nxt      = a_l;
      mp_nxt.idx  = !act ? a_l.idx : ((sz == '0) ? '0 : a_q);
      mp_nxt.gmap = off_w + gprod;
      mp_nxt.inr  = (coord >= off_w) && ({1'b0, coord} < span_end);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        mp_v_r <= 1'b0;
      end else if (en) begin
        mp_v_r <= a_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        mp_l_r   <= mp_nxt;
        mp_rel_r <= coord - off_w;
      end
    end

    ssag_div u_div_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (mp_v_r),
      .in_num   (mp_rel_r),
      .in_lane  (mp_l_r),
      .divisor  (stp),
      .out_valid(b_v),
      .out_num  (b_num),
      .out_q    (b_q),
      .out_r    (b_r),
      .out_lane (b_l)
    );

    assign mapped = (mode_r == MODE_SCATTER) ? b_q : b_l.gmap;
    assign bad    = act && (mode_r == MODE_SCATTER) &&
                    (!b_l.inr || (b_r != '0) || (b_num == '1 && stp == '0));

    always_comb begin
      m1_nxt     = b_l;
      m1_nxt.ok  = b_l.ok & ~bad;
      m2_nxt     = m1_l_r;
      m2_nxt.src = m1_l_r.src + m1_p_r;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        m1_v_r <= 1'b0;
        m2_v_r <= 1'b0;
      end else if (en) begin
        m1_v_r <= b_v;
        m2_v_r <= m1_v_r;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        m1_l_r <= m1_nxt;
        m1_p_r <= act ? (mapped * strd) : '0;
        m2_l_r <= m2_nxt;
      end
    end

    assign sv_w[j+1] = m2_v_r;
    assign sl_w[j+1] = m2_l_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sv_w[MAX_DIMS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_dest_r <= sl_w[MAX_DIMS].dest;
      out_src_r  <= sl_w[MAX_DIMS].ok ? sl_w[MAX_DIMS].src : '0;
      out_inb_r  <= sl_w[MAX_DIMS].ok;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_dest_index    = out_dest_r;
  assign out_source_offset = out_src_r;
  assign out_copy_src      = out_inb_r;

endmodule

@@ hdl/ssag_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssag_div
// Pipelined restoring divider, one quotient bit per stage, lane word carried
// along. User holds divisor static while words are in flight; not enforced.
// ----------------------------------------------------------------------------
module ssag_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [ssag_pkg::WORD_W-1:0]   in_num,
  input  ssag_pkg::lane_t               in_lane,
  input  logic [ssag_pkg::DIM_BITS-1:0] divisor,
  output logic                          out_valid,
  output logic [ssag_pkg::WORD_W-1:0]   out_num,
  output logic [ssag_pkg::WORD_W-1:0]   out_q,
  output logic [ssag_pkg::DIM_BITS-1:0] out_r,
  output ssag_pkg::lane_t               out_lane
);
  import ssag_pkg::*;

  logic                v_r   [WORD_W];
  logic [WORD_W-1:0]   num_r [WORD_W];
  logic [WORD_W-1:0]   q_r   [WORD_W];
  logic [DIM_BITS-1:0] r_r   [WORD_W];
  lane_t               l_r   [WORD_W];

  for (genvar i = 0; i < WORD_W; i++) begin : g_st
    logic                pv;
    logic [WORD_W-1:0]   pn;
    logic [WORD_W-1:0]   pq;
    logic [DIM_BITS-1:0] pr;
    lane_t               pl;
    logic [DIM_BITS:0]   rsh;
    logic                ge;
    logic [DIM_BITS:0]   rsub;

    if (i == 0) begin : g_first
      assign pv = in_valid;
      assign pn = in_num;
      assign pq = '0;
      assign pr = '0;
      assign pl = in_lane;
    end else begin : g_next
      assign pv = v_r[i-1];
      assign pn = num_r[i-1];
      assign pq = q_r[i-1];
      assign pr = r_r[i-1];
      assign pl = l_r[i-1];
    end

    assign rsh  = {pr, pn[WORD_W-1-i]};
    assign ge   = rsh >= {1'b0, divisor};
    assign rsub = rsh - {1'b0, divisor};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num_r[i] <= pn;
        q_r[i]   <= {pq[WORD_W-2:0], ge};
        r_r[i]   <= ge ? rsub[DIM_BITS-1:0] : rsh[DIM_BITS-1:0];
        l_r[i]   <= pl;
      end
    end
  end

  assign out_valid = v_r[WORD_W-1];
  assign out_num   = num_r[WORD_W-1];
  assign out_q     = q_r[WORD_W-1];
  assign out_r     = r_r[WORD_W-1];
  assign out_lane  = l_r[WORD_W-1];

endmodule
